// ----- src/cpft_pkg.sv -----
package cpft_pkg;

	localparam int TABLE_BITS_DEF   = 10;
	localparam int SAMPLE_WIDTH_DEF = 16;

	// guard bits kept on interpolated sine/cosine beyond the ROM lsb
	localparam int SINE_GUARD = 8;
	localparam int COEF_SHIFT = 30;

	// Q2.30 coefficients, rounded to nearest
	localparam logic signed [31:0] K_THIRD      = 32'sd357913941;
	localparam logic signed [31:0] K_INV_SQRT3  = 32'sd619925131;
	localparam logic signed [31:0] K_SQRT3_HALF = 32'sd929887697;

	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [63:0] HALF_PI_Q62  = 64'h6487_ED51_10B4_611A;

	typedef enum logic [1:0] {
		CMD_CLARKE     = 2'd0,
		CMD_INV_CLARKE = 2'd1,
		CMD_PARK       = 2'd2,
		CMD_INV_PARK   = 2'd3
	} cpft_cmd_t;

	// stage advance enables shared by the datapath and the sine lookup
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} cpft_adv_t;

	// (a*b) >> 62, elaboration only
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] pr;
		pr = {64'd0, a} * {64'd0, b};
		return pr[125:62];
	endfunction

	// floor(num / den) by shift and subtract, elaboration only
	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// ROM entry k: round(A * sin(2*pi*k / 2^tb)), A = 2^(sw-1)-1, via a Taylor series
	function automatic longint rom_entry(input logic [31:0] k_in, input int tb, input int sw);
		logic [31:0] quarter;
		logic [31:0] k;
		logic [31:0] quad;
		logic [31:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] amp;
		logic [63:0] val;
		logic [63:0] dv;
		int n;
		quarter = 32'd1 << (tb - 2);
		k = k_in & ((32'd1 << tb) - 32'd1);
		quad = k >> (tb - 2);
		r = k & (quarter - 32'd1);
		if (quad[0]) begin
			r = quarter - r;
		end
		x = (HALF_PI_Q62 >> (tb - 2)) * {32'd0, r};
		x2 = mul_q62(x, x);
		term = x;
		sum = x;
		for (n = 1; term != 64'd0 && n < 40; n++) begin
			dv = 64'(2 * n) * 64'(2 * n + 1);
			term = div_u64(mul_q62(term, x2), dv);
			if (n[0]) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		amp = (64'd1 << (sw - 1)) - 64'd1;
		val = (amp * (sum >> 22) + (64'd1 << 39)) >> 40;
		return (quad >= 32'd2) ? -longint'(val) : longint'(val);
	endfunction

endpackage

// ----- src/cpft_sincos.sv -----
// Interpolated sine and cosine, three stages: ROM read, slope multiply, round.
module cpft_sincos
	import cpft_pkg::*;
#(
	parameter int TABLE_BITS   = TABLE_BITS_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                                    clk,
	input  cpft_adv_t                               adv,
	input  logic [31:0]                             phase,
	output logic signed [SAMPLE_WIDTH+SINE_GUARD-1:0] sin_s3,
	output logic signed [SAMPLE_WIDTH+SINE_GUARD-1:0] cos_s3
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int TB    = TABLE_BITS;
	localparam int DEPTH = 1 << TB;
	localparam int F     = 32 - TB;
	localparam int PW    = F + SW + 2;
	localparam int VW    = SW + F + 2;
	localparam int SCW   = SW + SINE_GUARD;
	localparam int RSH   = F - SINE_GUARD;

	typedef logic signed [SW-1:0] rom_t [DEPTH];

	function automatic rom_t build_rom();
		rom_t r;
		for (int k = 0; k < DEPTH; k++) begin
			r[k] = SW'(rom_entry(32'(k), TB, SW));
		end
		return r;
	endfunction

	// one copy per lookup, each read at two addresses
	localparam rom_t SIN_ROM = build_rom();
	localparam rom_t COS_ROM = build_rom();

	logic [31:0]    phase_c;
	logic [TB-1:0]  si0, si1, ci0, ci1;

	logic signed [SW-1:0] sy0_s1, sy1_s1, cy0_s1, cy1_s1;
	logic [F-1:0]         sfrac_s1, cfrac_s1;

	logic signed [SW:0]   sdiff, cdiff;
	logic signed [PW-1:0] sprod_s2, cprod_s2;
	logic signed [SW-1:0] sy0_s2, cy0_s2;

	logic signed [VW-1:0] sv, cv;

	always_comb begin
		phase_c = phase + QUARTER_TURN;
		si0 = phase[31:F];
		si1 = si0 + TB'(1);
		ci0 = phase_c[31:F];
		ci1 = ci0 + TB'(1);
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			sy0_s1   <= SIN_ROM[si0];
			sy1_s1   <= SIN_ROM[si1];
			cy0_s1   <= COS_ROM[ci0];
			cy1_s1   <= COS_ROM[ci1];
			sfrac_s1 <= phase[F-1:0];
			cfrac_s1 <= phase_c[F-1:0];
		end
	end

	always_comb begin
		sdiff = (SW+1)'(sy1_s1) - (SW+1)'(sy0_s1);
		cdiff = (SW+1)'(cy1_s1) - (SW+1)'(cy0_s1);
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			sprod_s2 <= PW'($signed({1'b0, sfrac_s1}) * sdiff);
			cprod_s2 <= PW'($signed({1'b0, cfrac_s1}) * cdiff);
			sy0_s2   <= sy0_s1;
			cy0_s2   <= cy0_s1;
		end
	end

	always_comb begin
		sv = (VW'(sy0_s2) <<< F) + VW'(sprod_s2);
		cv = (VW'(cy0_s2) <<< F) + VW'(cprod_s2);
	end

	// round half up to Q1.(SW-1+guard)
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			sin_s3 <= SCW'((sv + (VW'(1) <<< (RSH - 1))) >>> RSH);
			cos_s3 <= SCW'((cv + (VW'(1) <<< (RSH - 1))) >>> RSH);
		end
	end

endmodule

// ----- src/clarke_park_frame_transform_top.sv -----
// channel  dir  tdata, lowest bit up                             tuser
// s_axis   in   in_first, in_second, in_third, phase, zero fill  command
// m_axis   out  out_first, out_second, out_third, zero fill      -
//
// One word per cycle sustained while m_axis_tready stays high; m_axis_tvalid rises once the
// accepted word has passed the six stage pipe: ROM read, slope multiply, sine round /
// coefficient multiply, rotation multiply, sum, round and saturate.
// Reset clears the stage valid bits only.
// A full stage holds while the next one is full and stalled; empty stages close up,
// so s_axis_tready stays high while any stage is free.
module clarke_park_frame_transform_top
	import cpft_pkg::*;
#(
	parameter int TABLE_BITS   = TABLE_BITS_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	localparam int IN_W  = ((3 * SAMPLE_WIDTH + 32 + 7) / 8) * 8,
	localparam int OUT_W = ((3 * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // in_first, in_second, in_third, phase
	input  logic [1:0]       s_axis_tuser,  // command
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata   // out_first, out_second, out_third
);

	localparam int SW         = SAMPLE_WIDTH;
	localparam int SCW        = SW + SINE_GUARD;
	localparam int PARK_SHIFT = SW - 1 + SINE_GUARD;
	localparam int ACC_W      = (SW + 34 > 2 * SW + 10) ? SW + 34 : 2 * SW + 10;

	localparam logic signed [ACC_W-1:0] HALF_C = ACC_W'(1) <<< (COEF_SHIFT - 1);
	localparam logic signed [ACC_W-1:0] HALF_P = ACC_W'(1) <<< (PARK_SHIFT - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (SW - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

	logic signed [SW-1:0] in_first, in_second, in_third;
	logic [31:0]          phase;
	cpft_cmd_t            command;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	cpft_adv_t adv;

	cpft_cmd_t            cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic signed [SW-1:0] p_s1, q_s1, z_s1;
	logic signed [SW-1:0] p_s2, q_s2, z_s2;
	logic signed [SW-1:0] p_s3, q_s3, z_s3;
	logic signed [SW-1:0] z_s4;
	logic signed [SW+1:0] t0_s2, t1_s2, t2_s2;
	logic signed [ACC_W-1:0] x0_s3, x1_s3, x2_s3;
	logic signed [ACC_W-1:0] w0_s4, w1_s4, w2_s4, w3_s4;
	logic signed [ACC_W-1:0] a0_s5, a1_s5, a2_s5;
	logic                    park_s5;
	logic signed [SW-1:0]    o0_s6, o1_s6, o2_s6;

	logic signed [SCW-1:0] sin_s3, cos_s3;

	assign in_first  = s_axis_tdata[SW-1:0];
	assign in_second = s_axis_tdata[2*SW-1:SW];
	assign in_third  = s_axis_tdata[3*SW-1:2*SW];
	assign phase     = s_axis_tdata[3*SW+31:3*SW];
	assign command   = cpft_cmd_t'(s_axis_tuser);

	// a stage may load when it is empty or its word moves on
	always_comb begin
		en_s6 = !v_s6 || m_axis_tready;
		en_s5 = !v_s5 || en_s6;
		en_s4 = !v_s4 || en_s5;
		en_s3 = !v_s3 || en_s4;
		en_s2 = !v_s2 || en_s3;
		en_s1 = !v_s1 || en_s2;
		adv.s1 = en_s1;
		adv.s2 = en_s2;
		adv.s3 = en_s3;
	end

	assign s_axis_tready = en_s1;
	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata  = OUT_W'({o2_s6, o1_s6, o0_s6});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_axis_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	cpft_sincos #(
		.TABLE_BITS   (TABLE_BITS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_sincos (
		.clk    (clk),
		.adv    (adv),
		.phase  (phase),
		.sin_s3 (sin_s3),
		.cos_s3 (cos_s3)
	);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			cmd_s1 <= command;
			p_s1   <= in_first;
			q_s1   <= in_second;
			z_s1   <= in_third;
		end
	end

	// Clarke pre-sums; inverse Clarke reuses t0 for a = alpha + zero
	always_ff @(posedge clk) begin
		if (en_s2) begin
			cmd_s2 <= cmd_s1;
			p_s2   <= p_s1;
			q_s2   <= q_s1;
			z_s2   <= z_s1;
			if (cmd_s1 == CMD_CLARKE) begin
				t0_s2 <= ((SW+2)'(p_s1) <<< 1) - (SW+2)'(q_s1) - (SW+2)'(z_s1);
			end else begin
				t0_s2 <= (SW+2)'(p_s1) + (SW+2)'(z_s1);
			end
			t1_s2 <= (SW+2)'(q_s1) - (SW+2)'(z_s1);
			t2_s2 <= (SW+2)'(p_s1) + (SW+2)'(q_s1) + (SW+2)'(z_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			cmd_s3 <= cmd_s2;
			p_s3   <= p_s2;
			q_s3   <= q_s2;
			z_s3   <= z_s2;
			case (cmd_s2)
				CMD_CLARKE: begin
					x0_s3 <= ACC_W'(t0_s2 * K_THIRD);
					x1_s3 <= ACC_W'(t1_s2 * K_INV_SQRT3);
					x2_s3 <= ACC_W'(t2_s2 * K_THIRD);
				end
				CMD_INV_CLARKE: begin
					x0_s3 <= ACC_W'(t0_s2) <<< COEF_SHIFT;
					x1_s3 <= ACC_W'(q_s2 * K_SQRT3_HALF);
					// zero - alpha/2
					x2_s3 <= (ACC_W'(z_s2) <<< COEF_SHIFT) - (ACC_W'(p_s2) <<< (COEF_SHIFT - 1));
				end
				default: begin
					x0_s3 <= '0;
					x1_s3 <= '0;
					x2_s3 <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			cmd_s4 <= cmd_s3;
			z_s4   <= z_s3;
			case (cmd_s3)
				CMD_PARK, CMD_INV_PARK: begin
					w0_s4 <= ACC_W'(p_s3 * cos_s3);
					w1_s4 <= ACC_W'(q_s3 * sin_s3);
					w2_s4 <= ACC_W'(q_s3 * cos_s3);
					w3_s4 <= ACC_W'(p_s3 * sin_s3);
				end
				default: begin
					w0_s4 <= x0_s3;
					w1_s4 <= x1_s3;
					w2_s4 <= x2_s3;
					w3_s4 <= '0;
				end
			endcase
		end
	end

	// everything lands aligned for one final round: 2^30 for Clarke, 2^PARK_SHIFT for Park
	always_ff @(posedge clk) begin
		if (en_s5) begin
			park_s5 <= (cmd_s4 == CMD_PARK) || (cmd_s4 == CMD_INV_PARK);
			case (cmd_s4)
				CMD_CLARKE: begin
					a0_s5 <= w0_s4;
					a1_s5 <= w1_s4;
					a2_s5 <= w2_s4;
				end
				CMD_INV_CLARKE: begin
					a0_s5 <= w0_s4;
					a1_s5 <= w2_s4 + w1_s4;
					a2_s5 <= w2_s4 - w1_s4;
				end
				CMD_PARK: begin
					a0_s5 <= w0_s4 + w1_s4;
					a1_s5 <= w2_s4 - w3_s4;
					a2_s5 <= ACC_W'(z_s4) <<< PARK_SHIFT;
				end
				CMD_INV_PARK: begin
					a0_s5 <= w0_s4 - w1_s4;
					a1_s5 <= w3_s4 + w2_s4;
					a2_s5 <= ACC_W'(z_s4) <<< PARK_SHIFT;
				end
				default: begin
					a0_s5 <= '0;
					a1_s5 <= '0;
					a2_s5 <= '0;
				end
			endcase
		end
	end

	function automatic logic signed [SW-1:0] rnd_sat(input logic signed [ACC_W-1:0] acc,
			input logic park);
		logic signed [ACC_W-1:0] r;
		if (park) begin
			r = (acc + HALF_P) >>> PARK_SHIFT;
		end else begin
			r = (acc + HALF_C) >>> COEF_SHIFT;
		end
		if (r > SAT_HI) begin
			r = SAT_HI;
		end else if (r < SAT_LO) begin
			r = SAT_LO;
		end
		return r[SW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en_s6) begin
			o0_s6 <= rnd_sat(a0_s5, park_s5);
			o1_s6 <= rnd_sat(a1_s5, park_s5);
			o2_s6 <= rnd_sat(a2_s5, park_s5);
		end
	end

endmodule

// ----- src/cpft_chk.sv -----
module cpft_chk
	import cpft_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	localparam int IN_W  = ((3 * SAMPLE_WIDTH + 32 + 7) / 8) * 8,
	localparam int OUT_W = ((3 * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic [IN_W-1:0]  s_axis_tdata,
	input logic [1:0]       s_axis_tuser,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	localparam int SW = SAMPLE_WIDTH;

	logic in_acc;
	logic in_park;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign in_park = (s_axis_tuser == CMD_PARK) || (s_axis_tuser == CMD_INV_PARK);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// an empty or draining output stage never backs up the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid || m_axis_tready |-> s_axis_tready)
		else $error("input stalled with free pipe");

	// an accepted word reaches the output when the sink keeps up
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
		##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
		else $error("word did not arrive after six cycles");

	// Park modes pass the zero-sequence value through
	a_park_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_park ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
		##1 m_axis_tready ##1 m_axis_tready |=>
		m_axis_tdata[3*SW-1:2*SW] == $past(s_axis_tdata[3*SW-1:2*SW], 6))
		else $error("zero-sequence value not passed through");

endmodule

bind clarke_park_frame_transform_top cpft_chk #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cpft_chk (.*);

// ----- tb/clarke_park_frame_transform_checker.sv -----
`timescale 1ns / 1ps

module clarke_park_frame_transform_checker
	import cpft_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // in_first, in_second, in_third, phase
	input  logic [1:0]  s_axis_tuser,  // command
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,  // out_first, out_second, out_third
	output int          fail_count,
	output int          outstanding
);

	localparam int LUT_SIZE = 1024;
	localparam int FRAC_W   = 22;
	localparam int PRINT_CAP = 100;

	typedef struct {
		logic signed [15:0] first;
		logic signed [15:0] second;
		logic signed [15:0] third;
	} frame_t;

	int     sine_lut [0:LUT_SIZE-1];
	frame_t expected_frames [$];

	// quarter-wave symmetric table: reflect odd quadrants, negate the lower half-turn
	initial begin
		int  k;
		int  quad;
		int  r;
		real mag;
		for (k = 0; k < LUT_SIZE; k++) begin
			quad = k / 256;
			r = k % 256;
			if (quad % 2 == 1) begin
				r = 256 - r;
			end
			mag = 32767.0 * $sin(3.14159265358979323846 / 2.0 * r / 256.0);
			sine_lut[k] = $rtoi($floor(mag + 0.5));
			if (quad >= 2) begin
				sine_lut[k] = -sine_lut[k];
			end
		end
	end

	initial begin
		fail_count = 0;
		outstanding = 0;
	end

	// floor((v + 2^(sh-1)) / 2^sh)
	function automatic longint round_q(input longint v, input int sh);
		return (v + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic logic signed [15:0] clamp16(input longint v);
		if (v > 32767) begin
			return 16'sh7FFF;
		end
		if (v < -32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// Q1.23 interpolated sine
	function automatic longint interp_sine(input logic [31:0] ph);
		logic [9:0] i0;
		logic [9:0] i1;
		longint     frac;
		longint     y0;
		longint     y1;
		i0 = ph[31:22];
		i1 = i0 + 10'd1;
		frac = longint'(ph[21:0]);
		y0 = longint'(sine_lut[i0]);
		y1 = longint'(sine_lut[i1]);
		return round_q(y0 * (longint'(1) <<< FRAC_W) + frac * (y1 - y0), FRAC_W - SINE_GUARD);
	endfunction

	function automatic frame_t predict_frame(input cpft_cmd_t cmd, input logic [79:0] word);
		longint      p;
		longint      q;
		longint      z;
		longint      s;
		longint      c;
		longint      r0;
		longint      r1;
		longint      r2;
		longint      half;
		longint      rot;
		longint      zz;
		logic [31:0] ph;
		int          rs;
		frame_t      f;
		p = longint'($signed(word[15:0]));
		q = longint'($signed(word[31:16]));
		z = longint'($signed(word[47:32]));
		ph = word[79:48];
		rs = 15 + SINE_GUARD;
		case (cmd)
			CMD_CLARKE: begin
				r0 = round_q((2 * p - q - z) * longint'(K_THIRD), COEF_SHIFT);
				r1 = round_q((q - z) * longint'(K_INV_SQRT3), COEF_SHIFT);
				r2 = round_q((p + q + z) * longint'(K_THIRD), COEF_SHIFT);
			end
			CMD_INV_CLARKE: begin
				half = -p * (longint'(1) <<< (COEF_SHIFT - 1));
				rot = longint'(K_SQRT3_HALF) * q;
				zz = z <<< COEF_SHIFT;
				r0 = p + z;
				r1 = round_q(half + rot + zz, COEF_SHIFT);
				r2 = round_q(half - rot + zz, COEF_SHIFT);
			end
			default: begin
				s = interp_sine(ph);
				c = interp_sine(ph + QUARTER_TURN);
				if (cmd == CMD_PARK) begin
					r0 = round_q(p * c + q * s, rs);
					r1 = round_q(q * c - p * s, rs);
				end else begin
					r0 = round_q(p * c - q * s, rs);
					r1 = round_q(p * s + q * c, rs);
				end
				r2 = z;
			end
		endcase
		f.first = clamp16(r0);
		f.second = clamp16(r1);
		f.third = clamp16(r2);
		return f;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (fail_count < PRINT_CAP) begin
			$display("%0t ns  %s: got %0d, want %0d", $time, what, got, want);
		end
		fail_count++;
	endtask

	always @(posedge clk) begin
		frame_t want;
		frame_t got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.first = m_axis_tdata[15:0];
				got.second = m_axis_tdata[31:16];
				got.third = m_axis_tdata[47:32];
				if (expected_frames.size() == 0) begin
					report_mismatch("output word with none pending, out_first",
						int'(got.first), 0);
				end else begin
					want = expected_frames.pop_front();
					if (got.first !== want.first) begin
						report_mismatch("out_first", int'(got.first), int'(want.first));
					end
					if (got.second !== want.second) begin
						report_mismatch("out_second", int'(got.second), int'(want.second));
					end
					if (got.third !== want.third) begin
						report_mismatch("out_third", int'(got.third), int'(want.third));
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_frames.push_back(predict_frame(cpft_cmd_t'(s_axis_tuser), s_axis_tdata));
			end
			outstanding = expected_frames.size();
		end
	end

endmodule

// ----- tb/clarke_park_frame_transform_top_tb.sv -----
`timescale 1ns / 1ps

module clarke_park_frame_transform_top_tb;
	import cpft_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = CMD_CLARKE;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;

	int   fail_count;
	int   outstanding;
	int   cycle_count = 0;
	int   burst_left = 0;
	bit   idle_on = 1'b1;
	bit   hold_req = 1'b0;

	always #4 clk = ~clk;

	clarke_park_frame_transform_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	clarke_park_frame_transform_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// output side: modes of random stall density, plus a long hold-off on request
	initial begin
		int       mode_left;
		int       rx_mode;
		logic     ready_next;
		logic [7:0] pattern;
		mode_left = 0;
		rx_mode = 0;
		pattern = 8'b1011_0110;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 128);
				end
				mode_left--;
				case (rx_mode)
					0: ready_next = 1'b1;
					1: ready_next = 1'($urandom_range(0, 1));
					2: ready_next = ($urandom_range(0, 9) != 0);
					default: begin
						ready_next = pattern[0];
						pattern = {pattern[0], pattern[7:1]};
					end
				endcase
				m_axis_tready <= ready_next;
				@(posedge clk);
			end
		end
	end

	task automatic push_word(input cpft_cmd_t cmd, input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] c, input logic [31:0] ph);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = idle_on ? $urandom_range(0, 8) : 0;
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {ph, c, b, a};
		s_axis_tuser <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
	endtask

	// stop offering and wait until every word sent has come back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					default: return 16'hFFFF;
				endcase
			end
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_phase();
		logic [9:0] idx;
		idx = 10'($urandom);
		case ($urandom_range(0, 7))
			0: return {idx, 22'h3FFFFF};
			1: return {idx, 22'h000000};
			2: return 32'hFFFF_FFFF - $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_items(input int count);
		repeat (count) begin
			push_word(cpft_cmd_t'($urandom_range(0, 3)), rand_sample(), rand_sample(),
				rand_sample(), rand_phase());
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// clarke: zero, saturation both ways, pure zero-sequence, phase ignored
		push_word(CMD_CLARKE, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
		push_word(CMD_CLARKE, 16'h7FFF, 16'h8000, 16'h8000, 32'h0000_0000);
		push_word(CMD_CLARKE, 16'h8000, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF);
		push_word(CMD_CLARKE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h1234_5678);
		push_word(CMD_CLARKE, 16'h0000, 16'h7FFF, 16'h8000, 32'h8000_0000);
		push_word(CMD_CLARKE, 16'd1000, -16'sd2000, 16'd1000, 32'hDEAD_BEEF);
		// inverse clarke: a = alpha + zero overflows, beta extremes
		push_word(CMD_INV_CLARKE, 16'h7FFF, 16'h0000, 16'h7FFF, 32'h0000_0000);
		push_word(CMD_INV_CLARKE, 16'h8000, 16'h0000, 16'h8000, 32'hFFFF_FFFF);
		push_word(CMD_INV_CLARKE, 16'h0000, 16'h7FFF, 16'h0000, 32'h4000_0000);
		push_word(CMD_INV_CLARKE, 16'h0000, 16'h8000, 16'h0000, 32'h0000_0000);
		push_word(CMD_INV_CLARKE, 16'h8000, 16'h8000, 16'h7FFF, 32'h0000_0000);
		// park: cardinal angles, cosine wrap, last table entry, 45 degree overflow
		push_word(CMD_PARK, 16'h7FFF, 16'h8000, 16'h0005, 32'h0000_0000);
		push_word(CMD_PARK, 16'h7FFF, 16'h8000, 16'h8000, 32'h4000_0000);
		push_word(CMD_PARK, 16'h4000, 16'hC000, 16'h7FFF, 32'hFFFF_FFFF);
		push_word(CMD_PARK, 16'h7FFF, 16'h7FFF, 16'h0000, 32'hFFE0_0000);
		push_word(CMD_PARK, 16'h8000, 16'h8000, 16'h0000, 32'h2000_0000);
		push_word(CMD_PARK, 16'h7FFF, 16'h7FFF, 16'hFFFF, 32'hBFFF_FFFF);
		push_word(CMD_PARK, 16'h1234, 16'hEDCB, 16'h0001, 32'h8000_0000);
		// inverse park
		push_word(CMD_INV_PARK, 16'h7FFF, 16'h7FFF, 16'h0000, 32'h2000_0000);
		push_word(CMD_INV_PARK, 16'h8000, 16'h7FFF, 16'h8000, 32'hC000_0000);
		push_word(CMD_INV_PARK, 16'h8000, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF);
		push_word(CMD_INV_PARK, 16'h5A5A, 16'hA5A5, 16'h1111, 32'h1234_5678);
		push_word(CMD_INV_PARK, 16'h7FFF, 16'h0000, 16'h0000, 32'hFFC0_0001);
		drain_results();

		idle_on = 1'b1;
		random_items(250);
		drain_results();

		// output held off while input keeps coming: pipe fills, tready must drop
		hold_req = 1'b1;
		idle_on = 1'b0;
		random_items(60);
		drain_results();

		random_items(200);
		idle_on = 1'b1;
		random_items(190);
		drain_results();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
